>>> rtl/triple_buffered_id_queue_assert.svh
// ----------------------------------------------------------------------------
// triple buffered id queue assertion macros
// shared property forms, clocked on clk and disabled during rst_n low
// ----------------------------------------------------------------------------
`ifndef TRIPLE_BUFFERED_ID_QUEUE_ASSERT_SVH
`define TRIPLE_BUFFERED_ID_QUEUE_ASSERT_SVH

// condition holds at every edge out of reset
`define TBQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TBQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TBQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tbq_pkg.sv
// ----------------------------------------------------------------------------
// tbq_pkg
// shared constants, command codes and control/status bundles
// ----------------------------------------------------------------------------
`default_nettype none

package tbq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int NUM_QUEUES  = 3;
  localparam int ID_W        = 16;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int SEL_W       = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH        = 3'd0,
    CMD_POP         = 3'd1,
    CMD_START_WRITE = 3'd2,
    CMD_STOP_WRITE  = 3'd3,
    CMD_START_READ  = 3'd4,
    CMD_STOP_READ   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;        // latch incoming beat
    logic exec;           // carry out the held command
    logic load_result;    // load result computed during exec
    logic load_pop_data;  // load popped id from store read
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic pop_hit;        // pop on a non-empty read queue
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/triple_buffered_id_queue.sv
// ----------------------------------------------------------------------------
// triple_buffered_id_queue
// three rotating id queues (read, write, spare) behind one command channel
// ----------------------------------------------------------------------------
// Each input beat carries one command and returns exactly one result beat.
// Push appends in_id_value to the write queue, pop takes the oldest id from
// the read queue, start write empties the write queue, stop write hands the
// write queue over to the reader (or to the spare role while a read is open,
// with the hand-over finished at stop read). The block works on one command
// at a time: a beat is taken, the command executes once the output register
// is free, and its result lands in the output register. A push, a failed pop
// or a role command loads its result on execute; a returned id is loaded in
// a further state from the registered read port of the 768 x 16 queue store.
// A new beat is accepted as soon as the previous result is registered, even
// while that result is still stalled; execution then waits for the output
// register to free up. The store has no reset and needs no clearing pass,
// since a pop only reads slots written by an earlier push.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_buffered_id_queue
  import tbq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command beat
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [ID_W-1:0]     in_id_value,
  // result beat
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [ID_W-1:0]          out_id_out,
  output logic [STATUS_W-1:0]      out_status
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  // sequencing: idle, execute, popped-data load
  tbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // queue store, heads, counts, role selectors and result register
  tbq_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_cmd      (in_cmd),
    .in_id_value (in_id_value),
    .out_id_out  (out_id_out),
    .out_status  (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/tbq_ctrl.sv
// ----------------------------------------------------------------------------
// tbq_ctrl
// sequencing state machine and output valid for the id queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "triple_buffered_id_queue_assert.svh"

module tbq_ctrl
  import tbq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output ctrl_t         ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ctrl               = '0;
    ctrl.capture       = (state_r == S_IDLE) && in_valid;
    ctrl.exec          = (state_r == S_EXEC) && out_free;
    ctrl.load_result   = ctrl.exec && !stat.pop_hit;
    ctrl.load_pop_data = (state_r == S_POPRD);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = stat.pop_hit ? S_POPRD : S_IDLE;
      end
      S_POPRD: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load_result || ctrl.load_pop_data) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `TBQ_ASSERT_ALWAYS(a_one_load, !(ctrl.load_result && ctrl.load_pop_data), "two result loads")
  `TBQ_ASSERT_NEXT(a_pop_follow, ctrl.exec && stat.pop_hit, ctrl.load_pop_data, "pop data lost")
  `TBQ_ASSERT_IMP(a_no_overwrite, ctrl.load_result || ctrl.load_pop_data,
                  !(out_valid_r && out_stall), "result overwrites held beat")

endmodule

`default_nettype wire

>>> rtl/tbq_datapath.sv
// ----------------------------------------------------------------------------
// tbq_datapath
// queue store, head and count registers, role selectors and output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "triple_buffered_id_queue_assert.svh"

module tbq_datapath
  import tbq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctrl_t               ctrl,
  output dp_stat_t                 stat,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [ID_W-1:0]     in_id_value,
  output logic [ID_W-1:0]          out_id_out,
  output logic [STATUS_W-1:0]      out_status
);

  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_POS  = PTR_W'(QUEUE_DEPTH - 1);

  logic [ID_W-1:0]  store [STORE_DEPTH];
  logic [ID_W-1:0]  rdata_r;

  cmd_t             cmd_r;
  logic [ID_W-1:0]  id_r;

  logic [PTR_W-1:0] heads_r  [NUM_QUEUES];
  logic [CNT_W-1:0] counts_r [NUM_QUEUES];
  logic [SEL_W-1:0] read_sel_r, write_sel_r, spare_sel_r;
  logic             reading_open_r, swap_pending_r;

  logic [ID_W-1:0]     out_id_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [PTR_W-1:0]  w_head, r_head, w_pos, r_head_nxt;
  logic [CNT_W-1:0]  w_cnt, r_cnt;
  logic [PTR_W:0]    w_sum;
  logic              w_full, r_empty;
  logic [ADDR_W-1:0] w_addr, r_addr;
  status_t           res_status;

  assign w_head = heads_r[write_sel_r];
  assign w_cnt  = counts_r[write_sel_r];
  assign r_head = heads_r[read_sel_r];
  assign r_cnt  = counts_r[read_sel_r];

  assign w_full  = (w_cnt == DEPTH_CNT);
  assign r_empty = (r_cnt == '0);

  // tail slot wraps at most once since head is below depth and only the low bits of count are added
  assign w_sum = {1'b0, w_head} + {1'b0, w_cnt[PTR_W-1:0]};
  assign w_pos = (w_sum >= DEPTH_EXT) ? PTR_W'(w_sum - DEPTH_EXT) : w_sum[PTR_W-1:0];

  assign r_head_nxt = (r_head == LAST_POS) ? '0 : r_head + PTR_W'(1);

  assign w_addr = ADDR_W'(int'(write_sel_r) * QUEUE_DEPTH) + ADDR_W'(w_pos);
  assign r_addr = ADDR_W'(int'(read_sel_r) * QUEUE_DEPTH) + ADDR_W'(r_head);

  always_comb begin
    res_status = ST_OK;
    case (cmd_r)
      CMD_PUSH: if (w_full)  res_status = ST_FULL;
      CMD_POP:  if (r_empty) res_status = ST_EMPTY;
      default:  res_status = ST_OK;
    endcase
  end

  assign stat.pop_hit = (cmd_r == CMD_POP) && !r_empty;

  // held beat
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= cmd_t'(in_cmd);
      id_r  <= in_id_value;
    end
  end

  // queue store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.exec && (cmd_r == CMD_PUSH) && !w_full) begin
      store[w_addr] <= id_r;
    end
    if (ctrl.exec) begin
      rdata_r <= store[r_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads_r[i]  <= '0;
        counts_r[i] <= '0;
      end
      read_sel_r     <= SEL_W'(0);
      write_sel_r    <= SEL_W'(1);
      spare_sel_r    <= SEL_W'(2);
      reading_open_r <= 1'b0;
      swap_pending_r <= 1'b0;
    end else if (ctrl.exec) begin
      unique case (cmd_r)
        CMD_PUSH: begin
          if (!w_full) counts_r[write_sel_r] <= w_cnt + CNT_W'(1);
        end
        CMD_POP: begin
          if (!r_empty) begin
            heads_r[read_sel_r]  <= r_head_nxt;
            counts_r[read_sel_r] <= r_cnt - CNT_W'(1);
          end
        end
        CMD_START_WRITE: begin
          heads_r[write_sel_r]  <= '0;
          counts_r[write_sel_r] <= '0;
        end
        CMD_STOP_WRITE: begin
          if (reading_open_r) begin
            swap_pending_r <= 1'b1;
            spare_sel_r    <= write_sel_r;
            write_sel_r    <= spare_sel_r;
          end else begin
            read_sel_r  <= write_sel_r;
            write_sel_r <= read_sel_r;
          end
        end
        CMD_START_READ: begin
          reading_open_r <= 1'b1;
        end
        CMD_STOP_READ: begin
          if (swap_pending_r) begin
            read_sel_r     <= spare_sel_r;
            spare_sel_r    <= read_sel_r;
            swap_pending_r <= 1'b0;
          end
          reading_open_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.load_result) begin
      out_id_r     <= '0;
      out_status_r <= res_status;
    end else if (ctrl.load_pop_data) begin
      out_id_r     <= rdata_r;
      out_status_r <= ST_OK;
    end
  end

  assign out_id_out = out_id_r;
  assign out_status = out_status_r;

  `TBQ_ASSERT_ALWAYS(a_roles_distinct,
                     (read_sel_r != write_sel_r) && (read_sel_r != spare_sel_r) &&
                     (write_sel_r != spare_sel_r), "queue roles collide")
  `TBQ_ASSERT_ALWAYS(a_count_bound,
                     (counts_r[0] <= DEPTH_CNT) && (counts_r[1] <= DEPTH_CNT) &&
                     (counts_r[2] <= DEPTH_CNT), "queue count past depth")
  `TBQ_ASSERT_IMP(a_pending_in_read, swap_pending_r, reading_open_r,
                  "pending swap outside a read")

endmodule

`default_nettype wire
